/* rtl/msep_pkg.sv */
// ----------------------------------------------------------------------------
// msep_pkg: shared types and constants for the mesh shared edge pair counter
// Holds the controller state type, the command and status bundles between
// controller and datapath, and the slot tables of the edge placement checks.
// ----------------------------------------------------------------------------
`default_nettype none

package msep_pkg;

	localparam int MAX_TRIANGLES_DEF = 1024;
	localparam int VERTEX_BITS_DEF   = 16;
	localparam int IN_VERTEX_W       = 16;
	localparam int COUNT_W           = 24;
	localparam int CHECKS            = 18;
	localparam int HIT_W             = 5;

	// placement k puts the edge into slots P/Q of triangle j, R is the rest
	localparam logic [1:0] SLOT_P [3] = '{2'd0, 2'd0, 2'd1};
	localparam logic [1:0] SLOT_Q [3] = '{2'd1, 2'd2, 2'd2};
	localparam logic [1:0] SLOT_R [3] = '{2'd2, 2'd1, 2'd0};

	// edge e of triangle i runs U-V, W is the opposite vertex
	localparam logic [1:0] EDGE_U [3] = '{2'd0, 2'd1, 2'd2};
	localparam logic [1:0] EDGE_V [3] = '{2'd1, 2'd2, 2'd0};
	localparam logic [1:0] EDGE_W [3] = '{2'd2, 2'd0, 2'd1};

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_FETCH,
		ST_CAPI,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic store_wr;
		logic rd_i;
		logic cap_i;
		logic rd_j;
		logic adv_i;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic j_last;
		logic i_last;
		logic pipe_busy;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/msep_ram.sv */
// ----------------------------------------------------------------------------
// msep_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module msep_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/msep_ctrl.sv */
// ----------------------------------------------------------------------------
// msep_ctrl: sequencer of the mesh shared edge pair counter
// Loads triangles, then walks every ordered pair of stored triangles and
// issues the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module msep_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            last_triangle,
	input  wire msep_pkg::stat_t stat,
	output msep_pkg::cmd_t       cmd,
	output logic                 busy
);

	msep_pkg::state_t state_q;
	msep_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msep_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			msep_pkg::ST_LOAD: begin
				if (start && last_triangle) begin
					state_d = msep_pkg::ST_FETCH;
				end
			end
			msep_pkg::ST_FETCH: begin
				state_d = msep_pkg::ST_CAPI;
			end
			msep_pkg::ST_CAPI, msep_pkg::ST_SWEEP: begin
				if (stat.j_last) begin
					state_d = stat.i_last ? msep_pkg::ST_DRAIN : msep_pkg::ST_FETCH;
				end else begin
					state_d = msep_pkg::ST_SWEEP;
				end
			end
			msep_pkg::ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = msep_pkg::ST_DONE;
				end
			end
			msep_pkg::ST_DONE: begin
				state_d = msep_pkg::ST_LOAD;
			end
			default: begin
				state_d = msep_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			msep_pkg::ST_LOAD: begin
				busy         = 1'b0;
				cmd.store_wr = start;
			end
			msep_pkg::ST_FETCH: begin
				cmd.rd_i = 1'b1;
			end
			msep_pkg::ST_CAPI: begin
				cmd.cap_i = 1'b1;
				cmd.rd_j  = 1'b1;
				cmd.adv_i = stat.j_last && !stat.i_last;
			end
			msep_pkg::ST_SWEEP: begin
				cmd.rd_j  = 1'b1;
				cmd.adv_i = stat.j_last && !stat.i_last;
			end
			msep_pkg::ST_DRAIN: begin
				cmd = '0;
			end
			msep_pkg::ST_DONE: begin
				cmd.emit = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_fetch_then_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_i |=> cmd.cap_i)
		else $error("row fetch not followed by capture");

	a_emit_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == msep_pkg::ST_LOAD) && !busy)
		else $error("block not idle after result");

	a_no_read_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.rd_j && !cmd.rd_i && !cmd.emit)
		else $error("compare command while idle");

endmodule

`default_nettype wire

/* rtl/msep_dp.sv */
// ----------------------------------------------------------------------------
// msep_dp: datapath of the mesh shared edge pair counter
// Triangle store, pair counters, the 18-way placement check and the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module msep_dp #(
	parameter int MAX_TRIANGLES = msep_pkg::MAX_TRIANGLES_DEF,
	parameter int VERTEX_BITS   = msep_pkg::VERTEX_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire msep_pkg::cmd_t                   cmd,
	input  wire logic [msep_pkg::IN_VERTEX_W-1:0] vertex_a,
	input  wire logic [msep_pkg::IN_VERTEX_W-1:0] vertex_b,
	input  wire logic [msep_pkg::IN_VERTEX_W-1:0] vertex_c,
	output msep_pkg::stat_t                       stat,
	output logic [msep_pkg::COUNT_W-1:0]          pair_count,
	output logic                                  done
);

	localparam int IDX_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
	localparam int SUM_W = 2 * CNT_W + 5;
	localparam int TRI_W = 3 * VERTEX_BITS;
	localparam int EXT_W = SUM_W + msep_pkg::COUNT_W;

	logic [CNT_W-1:0]       total_q;
	logic [IDX_W-1:0]       i_q;
	logic [IDX_W-1:0]       j_q;
	logic [TRI_W-1:0]       wdata;
	logic [TRI_W-1:0]       rdata;
	logic [IDX_W-1:0]       raddr;
	logic                   full;
	logic                   we;
	logic [VERTEX_BITS-1:0] tri_i_q [3];
	logic [VERTEX_BITS-1:0] tri_j [3];
	logic                   valid_s1;
	logic                   valid_s2;
	logic [msep_pkg::CHECKS-1:0] chk;
	logic [msep_pkg::CHECKS-1:0] chk_s2;
	logic [SUM_W-1:0]       sum_q;
	logic [EXT_W-1:0]       half;

	assign full  = (total_q == CNT_W'(MAX_TRIANGLES));
	assign we    = cmd.store_wr && !full;
	assign wdata = {VERTEX_BITS'(vertex_c), VERTEX_BITS'(vertex_b), VERTEX_BITS'(vertex_a)};
	assign raddr = cmd.rd_i ? i_q : j_q;

	msep_ram #(
		.WIDTH (TRI_W),
		.DEPTH (MAX_TRIANGLES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (total_q[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign stat.j_last    = ((CNT_W'(j_q) + CNT_W'(1)) == total_q);
	assign stat.i_last    = ((CNT_W'(i_q) + CNT_W'(1)) == total_q);
	assign stat.pipe_busy = valid_s1 || valid_s2;

	// count and row/column pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			if (cmd.emit) begin
				total_q <= '0;
				i_q     <= '0;
			end else begin
				if (we) begin
					total_q <= total_q + CNT_W'(1);
				end
				if (cmd.adv_i) begin
					i_q <= i_q + IDX_W'(1);
				end
			end
			if (cmd.rd_i) begin
				j_q <= '0;
			end else if (cmd.rd_j) begin
				j_q <= j_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_i) begin
			for (int s = 0; s < 3; s++) begin
				tri_i_q[s] <= rdata[s*VERTEX_BITS +: VERTEX_BITS];
			end
		end
	end

	always_comb begin
		for (int s = 0; s < 3; s++) begin
			tri_j[s] = rdata[s*VERTEX_BITS +: VERTEX_BITS];
		end
	end

	// two placements per (edge, slot pair): forward and reversed
	always_comb begin
		logic             r_ok;
		logic [1:0]       p;
		logic [1:0]       q;
		logic [1:0]       r;
		logic [1:0]       u;
		logic [1:0]       v;
		logic [1:0]       w;
		for (int e = 0; e < 3; e++) begin
			for (int k = 0; k < 3; k++) begin
				p    = msep_pkg::SLOT_P[k];
				q    = msep_pkg::SLOT_Q[k];
				r    = msep_pkg::SLOT_R[k];
				u    = msep_pkg::EDGE_U[e];
				v    = msep_pkg::EDGE_V[e];
				w    = msep_pkg::EDGE_W[e];
				r_ok = (tri_j[r] != tri_i_q[w]);
				chk[(e*3 + k)*2]     = r_ok && (tri_j[p] == tri_i_q[u])
					&& (tri_j[q] == tri_i_q[v]);
				chk[(e*3 + k)*2 + 1] = r_ok && (tri_j[p] == tri_i_q[v])
					&& (tri_j[q] == tri_i_q[u]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_j;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		chk_s2 <= chk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.emit) begin
			sum_q <= '0;
		end else if (valid_s2) begin
			sum_q <= sum_q + SUM_W'(msep_pkg::HIT_W'($countones(chk_s2)));
		end
	end

	assign half = EXT_W'(sum_q) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (|half[EXT_W-1:msep_pkg::COUNT_W]) begin
				pair_count <= '1;
			end else begin
				pair_count <= half[msep_pkg::COUNT_W-1:0];
			end
		end
	end

	a_compare_has_rows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (total_q != '0))
		else $error("compare beat with empty store");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (total_q == '0) && (sum_q == '0) && !valid_s1 && !valid_s2)
		else $error("state not cleared at result beat");

endmodule

`default_nettype wire

/* rtl/mesh_shared_edge_pair_counter.sv */
// ----------------------------------------------------------------------------
// mesh_shared_edge_pair_counter: top level
// Loads a triangle mesh and reports half the number of matching edge
// placements over all ordered pairs of stored triangles.
// ----------------------------------------------------------------------------
// Usage: present a triangle on vertex_a/b/c with last_triangle and raise
// start; the beat is taken on a rising edge where start is high and busy is
// low. While loading, busy stays low and one triangle goes in every cycle;
// triangles beyond MAX_TRIANGLES are dropped. The beat marked last_triangle
// starts the count: busy then stays high, and done pulses for one cycle with
// pair_count in the first cycle that busy is low again. The sweep is paced
// by the single read port of the triangle store: each row triangle is
// fetched first, then every stored triangle is read against it, one per
// cycle; the pipeline drains and the result beat follows the last read.
// The result beat cannot be held off, so take pair_count in the cycle done
// is high. After the result the store and sum are empty, ready for the next
// mesh.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_shared_edge_pair_counter #(
	parameter int MAX_TRIANGLES = msep_pkg::MAX_TRIANGLES_DEF,
	parameter int VERTEX_BITS   = msep_pkg::VERTEX_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [msep_pkg::IN_VERTEX_W-1:0] vertex_a,
	input  wire logic [msep_pkg::IN_VERTEX_W-1:0] vertex_b,
	input  wire logic [msep_pkg::IN_VERTEX_W-1:0] vertex_c,
	input  wire logic                             last_triangle,
	output logic                                  done,
	output logic [msep_pkg::COUNT_W-1:0]          pair_count
);

	msep_pkg::cmd_t  cmd;
	msep_pkg::stat_t stat;

	// sequencer: load, then walk rows and columns, then emit
	msep_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.last_triangle (last_triangle),
		.stat          (stat),
		.cmd           (cmd),
		.busy          (busy)
	);

	// store, placement checks and running sum
	msep_dp #(
		.MAX_TRIANGLES (MAX_TRIANGLES),
		.VERTEX_BITS   (VERTEX_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.vertex_a   (vertex_a),
		.vertex_b   (vertex_b),
		.vertex_c   (vertex_c),
		.stat       (stat),
		.pair_count (pair_count),
		.done       (done)
	);

endmodule

`default_nettype wire
